FILE: hdl/gsds_pkg.sv
package gsds_pkg;

  localparam int MAX_COLUMNS     = 4096;
  localparam int MAX_ROWS        = 256;
  localparam int CODE_TABLE_SIZE = 256;
  localparam int SKIPPED_CODES   = 32;
  localparam int GLYPH_SLOTS     = CODE_TABLE_SIZE - SKIPPED_CODES;

  localparam int COL_W = 12;
  localparam int ROW_W = 8;

  localparam int EVT_DEPTH = 2;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_GLYPH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One classified pixel, as handed from the front to the back.
  typedef struct packed {
    logic             mark;
    logic             col_end;
    logic             img_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } evt_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  glyph_code;
    logic [11:0] glyph_offset;
    logic [12:0] glyph_width;
    logic [8:0]  top_row;
    logic [8:0]  bottom_row;
    logic [8:0]  char_total;
    logic        table_overflow;
    logic        last_result;
  } res_t;

  // Up to two results written in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } res_wr_t;

endpackage

FILE: hdl/glyph_strip_delimiter_scanner.sv
// Channel   Handshake                    Payload
// pixels    push / full                  alpha_i
// results   empty / pop                  kind_o .. last_result_o
// config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One pixel is taken every cycle while full is low; the front counts rows and
// columns and flags zero-alpha pixels. The pixel of a result is first written
// into the event queue, where the glyph tracker reads it and writes the result
// queue; the result is then popped from the head of that queue.
// The glyph tracker writes up to two results a cycle into a four-entry
// result queue and waits while that queue lacks room, which fills the
// two-entry event queue and then raises full.
// Reset empties both queues, clears the scan and sets the image to
// 4096 by 16 pixels; there is no clearing pass.
module glyph_strip_delimiter_scanner import gsds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        alpha_i,
  output logic              empty,
  input  logic              pop,
  output logic              kind_o,
  output logic [7:0]        glyph_code_o,
  output logic [11:0]       glyph_offset_o,
  output logic [12:0]       glyph_width_o,
  output logic signed [8:0] top_row_o,
  output logic signed [8:0] bottom_row_o,
  output logic [8:0]        char_total_o,
  output logic              table_overflow_o,
  output logic              last_result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [12:0]       cfg_data_i
);

  logic                 evt_push;
  evt_t                 evt_in;
  logic                 evt_full;
  logic                 evt_valid;
  evt_t                 evt_head;
  logic                 evt_pop;
  logic [RES_CNT_W-1:0] res_free;
  res_wr_t              res_wr;
  res_t                 res_head;

  gsds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .alpha_i     (alpha_i),
    .evt_full_i  (evt_full),
    .evt_push_o  (evt_push),
    .evt_o       (evt_in),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  gsds_evt_fifo u_evt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .data_i  (evt_in),
    .full_o  (evt_full),
    .valid_o (evt_valid),
    .data_o  (evt_head),
    .pop_i   (evt_pop)
  );

  gsds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_i       (evt_head),
    .evt_pop_o   (evt_pop),
    .res_free_i  (res_free),
    .res_wr_o    (res_wr)
  );

  gsds_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .free_o  (res_free),
    .empty_o (empty),
    .head_o  (res_head),
    .pop_i   (pop)
  );

  assign full             = evt_full;
  assign kind_o           = res_head.kind;
  assign glyph_code_o     = res_head.glyph_code;
  assign glyph_offset_o   = res_head.glyph_offset;
  assign glyph_width_o    = res_head.glyph_width;
  assign top_row_o        = $signed(res_head.top_row);
  assign bottom_row_o     = $signed(res_head.bottom_row);
  assign char_total_o     = res_head.char_total;
  assign table_overflow_o = res_head.table_overflow;
  assign last_result_o    = res_head.last_result;

endmodule

FILE: hdl/gsds_front.sv
module gsds_front import gsds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [7:0]  alpha_i,
  input  logic        evt_full_i,
  output logic        evt_push_o,
  output evt_t        evt_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [COL_W-1:0] wm1_q, wm1_d;
  logic [ROW_W-1:0] hm1_q, hm1_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;
  logic             col_end;
  logic             img_end;
  logic [8:0]       hgt_val;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !evt_full_i;
  assign col_end     = (row_q >= hm1_q);
  assign img_end     = col_end && (col_q >= wm1_q);
  assign hgt_val     = cfg_data_i[8:0];

  // The registers keep the clamped dimension minus one.
  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          if (cfg_data_i == '0) begin
            wm1_d = '0;
          end else if (cfg_data_i > 13'(MAX_COLUMNS)) begin
            wm1_d = COL_W'(MAX_COLUMNS - 1);
          end else begin
            wm1_d = COL_W'(cfg_data_i - 13'd1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (hgt_val == '0) begin
            hm1_d = '0;
          end else if (hgt_val > 9'(MAX_ROWS)) begin
            hm1_d = ROW_W'(MAX_ROWS - 1);
          end else begin
            hm1_d = ROW_W'(hgt_val - 9'd1);
          end
        end
        default: begin
          wm1_d = wm1_q;
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (img_end) begin
        col_d = '0;
        row_d = '0;
      end else if (col_end) begin
        col_d = col_q + COL_W'(1);
        row_d = '0;
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  assign evt_push_o    = accept;
  assign evt_o.mark    = (alpha_i == 8'd0);
  assign evt_o.col_end = col_end;
  assign evt_o.img_end = img_end;
  assign evt_o.row     = row_q;
  assign evt_o.col     = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= COL_W'(MAX_COLUMNS - 1);
      hm1_q <= ROW_W'(15);
      col_q <= '0;
      row_q <= '0;
    end else begin
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hdl/gsds_evt_fifo.sv
module gsds_evt_fifo import gsds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t data_i,
  output logic full_o,
  output logic valid_o,
  output evt_t data_o,
  input  logic pop_i
);

  localparam int PTR_W = $clog2(EVT_DEPTH);
  localparam int CNT_W = $clog2(EVT_DEPTH + 1);

  evt_t             mem_q [EVT_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(EVT_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? PTR_W'(wptr_q + PTR_W'(1)) : wptr_q;
    rptr_d  = do_pop  ? PTR_W'(rptr_q + PTR_W'(1)) : rptr_q;
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: hdl/gsds_back.sv
module gsds_back import gsds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 evt_valid_i,
  input  evt_t                 evt_i,
  output logic                 evt_pop_o,
  input  logic [RES_CNT_W-1:0] res_free_i,
  output res_wr_t              res_wr_o
);

  logic [8:0]  top_q, top_d, top_n;
  logic [8:0]  bot_q, bot_d, bot_n;
  logic [7:0]  glyphs_q, glyphs_d, glyphs_n;
  logic [12:0] start_q, start_d, start_n;
  logic        closed_q, closed_d;
  logic        ovf_q, ovf_d, ovf_n;

  logic        first_col;
  logic        mark_take;
  logic        close_mark;
  logic        close_first;
  logic        do_close;
  logic        tbl_full;
  logic        emit_glyph;
  logic [1:0]  n_res;
  logic        take;
  res_t        glyph_rec;
  res_t        sum_rec;

  always_comb begin
    // Until glyph 32 is closed every mark of the marker column counts.
    first_col  = (glyphs_q == '0);
    mark_take  = evt_i.mark && !closed_q;
    top_n      = top_q;
    bot_n      = bot_q;
    if (mark_take && first_col) begin
      if (top_q[8]) begin
        top_n = {1'b0, evt_i.row};
      end
      bot_n = {1'b0, evt_i.row};
    end
    close_mark  = mark_take && !first_col;
    close_first = evt_i.col_end && first_col && !top_n[8];
    do_close    = close_mark || close_first;
    tbl_full    = (glyphs_q >= 8'(GLYPH_SLOTS));

    glyphs_n = glyphs_q;
    ovf_n    = ovf_q;
    start_n  = start_q;
    if (do_close) begin
      start_n = {1'b0, evt_i.col} + 13'd1;
      if (tbl_full) begin
        ovf_n = 1'b1;
      end else begin
        glyphs_n = glyphs_q + 8'd1;
      end
    end
    emit_glyph = do_close && !tbl_full;

    glyph_rec.kind           = KIND_GLYPH;
    glyph_rec.glyph_code     = 8'(SKIPPED_CODES) + glyphs_q;
    glyph_rec.glyph_offset   = start_q[11:0];
    glyph_rec.glyph_width    = {1'b0, evt_i.col} + 13'd1 - start_q;
    glyph_rec.top_row        = top_n;
    glyph_rec.bottom_row     = bot_n;
    glyph_rec.char_total     = {1'b0, glyphs_n} + 9'(SKIPPED_CODES);
    glyph_rec.table_overflow = ovf_n;
    glyph_rec.last_result    = !evt_i.img_end;

    sum_rec              = glyph_rec;
    sum_rec.kind         = KIND_SUMMARY;
    sum_rec.glyph_code   = '0;
    sum_rec.glyph_offset = '0;
    sum_rec.glyph_width  = '0;
    sum_rec.last_result  = 1'b1;

    n_res = {1'b0, emit_glyph} + {1'b0, evt_i.img_end};
    take  = evt_valid_i && (res_free_i >= RES_CNT_W'(n_res));

    res_wr_o.cnt    = take ? n_res : 2'd0;
    res_wr_o.first  = emit_glyph ? glyph_rec : sum_rec;
    res_wr_o.second = sum_rec;
  end

  assign evt_pop_o = take;

  always_comb begin
    top_d    = top_q;
    bot_d    = bot_q;
    glyphs_d = glyphs_q;
    start_d  = start_q;
    closed_d = closed_q;
    ovf_d    = ovf_q;
    if (take) begin
      if (evt_i.img_end) begin
        top_d    = '1;
        bot_d    = '1;
        glyphs_d = '0;
        start_d  = '0;
        closed_d = 1'b0;
        ovf_d    = 1'b0;
      end else begin
        top_d    = top_n;
        bot_d    = bot_n;
        glyphs_d = glyphs_n;
        start_d  = start_n;
        ovf_d    = ovf_n;
        if (evt_i.col_end) begin
          closed_d = 1'b0;
        end else if (close_mark) begin
          closed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '1;
      bot_q    <= '1;
      glyphs_q <= '0;
      start_q  <= '0;
      closed_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      top_q    <= top_d;
      bot_q    <= bot_d;
      glyphs_q <= glyphs_d;
      start_q  <= start_d;
      closed_q <= closed_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

FILE: hdl/gsds_res_fifo.sv
module gsds_res_fifo import gsds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  res_wr_t              wr_i,
  output logic [RES_CNT_W-1:0] free_o,
  output logic                 empty_o,
  output res_t                 head_o,
  input  logic                 pop_i
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr_q, wptr_d;
  logic [RES_PTR_W-1:0] rptr_q, rptr_d;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic [RES_PTR_W-1:0] wptr_nxt;
  logic                 do_pop;

  assign empty_o  = (count_q == '0);
  assign free_o   = RES_CNT_W'(RES_DEPTH) - count_q;
  assign head_o   = mem_q[rptr_q];
  assign do_pop   = pop_i && !empty_o;
  assign wptr_nxt = wptr_q + RES_PTR_W'(1);

  always_comb begin
    wptr_d  = wptr_q + RES_PTR_W'(wr_i.cnt);
    rptr_d  = do_pop ? RES_PTR_W'(rptr_q + RES_PTR_W'(1)) : rptr_q;
    count_d = count_q + RES_CNT_W'(wr_i.cnt) - RES_CNT_W'(do_pop);
  end

  // The writer never asks for more entries than free_o shows.
  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= wr_i.first;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wptr_nxt] <= wr_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: hdl/gsds_checker.sv
module gsds_checker import gsds_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              kind_o,
  input logic [7:0]        glyph_code_o,
  input logic [11:0]       glyph_offset_o,
  input logic [12:0]       glyph_width_o,
  input logic signed [8:0] top_row_o,
  input logic signed [8:0] bottom_row_o,
  input logic [8:0]        char_total_o,
  input logic              last_result_o
);

  // A summary always closes the request that caused it.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_SUMMARY) |-> last_result_o)
    else $error("summary result without last_result");

  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_SUMMARY) |->
      (glyph_code_o == 8'd0 && glyph_offset_o == 12'd0 && glyph_width_o == 13'd0))
    else $error("summary result carries glyph fields");

  // The count in a glyph record already includes that glyph.
  a_glyph_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_GLYPH) |->
      (char_total_o == {1'b0, glyph_code_o} + 9'd1))
    else $error("glyph code does not match char_total");

  a_marker_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((top_row_o == -9'sd1 && bottom_row_o == -9'sd1) ||
                (top_row_o >= 9'sd0 && bottom_row_o >= top_row_o)))
    else $error("marker rows inconsistent");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(glyph_code_o) && $stable(kind_o)))
    else $error("waiting result changed");

endmodule

bind glyph_strip_delimiter_scanner gsds_checker u_gsds_checker (.*);

FILE: tb/sv/glyph_strip_delimiter_scanner_tb.sv
module glyph_strip_delimiter_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsds_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_PIXELS = 1400;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SPARSE
  } rx_mode_e;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  logic [7:0]        alpha_i     = '0;
  logic              empty;
  logic              pop         = 1'b0;
  logic              kind_o;
  logic [7:0]        glyph_code_o;
  logic [11:0]       glyph_offset_o;
  logic [12:0]       glyph_width_o;
  logic signed [8:0] top_row_o;
  logic signed [8:0] bottom_row_o;
  logic [8:0]        char_total_o;
  logic              table_overflow_o;
  logic              last_result_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  cfg_reg_e          cfg_index_i = REG_IMAGE_WIDTH;
  logic [12:0]       cfg_data_i  = '0;

  glyph_strip_delimiter_scanner u_dut (.*);

  // Scanner state as the testbench expects it.
  logic [12:0] reg_width  = 13'd4096;
  logic [8:0]  reg_height = 9'd16;
  int unsigned scan_col, scan_row, glyph_count, glyph_start;
  int          marker_top    = -1;
  int          marker_bottom = -1;
  bit          col_done, table_full;

  res_t        step_out[$];
  res_t        pending_records[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  int unsigned burst_left;
  int unsigned rx_left;
  rx_mode_e    rx_mode = RX_STREAM;
  logic [1:0]  rx_phase = '0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void restart_scan();
    scan_col      = 0;
    scan_row      = 0;
    marker_top    = -1;
    marker_bottom = -1;
    glyph_count   = 0;
    glyph_start   = 0;
    col_done      = 1'b0;
    table_full    = 1'b0;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top_v);
    if (v < 1) return 1;
    if (v > top_v) return top_v;
    return v;
  endfunction

  function automatic res_t status_record(kind_e k, logic [7:0] code, logic [11:0] offs,
                                        logic [12:0] wid);
    res_t        r;
    int unsigned total;
    total = glyph_count + SKIPPED_CODES;
    if (total > 511) total = 511;
    r.kind           = k;
    r.glyph_code     = code;
    r.glyph_offset   = offs;
    r.glyph_width    = wid;
    r.top_row        = marker_top[8:0];
    r.bottom_row     = marker_bottom[8:0];
    r.char_total     = total[8:0];
    r.table_overflow = table_full;
    r.last_result    = 1'b0;
    return r;
  endfunction

  // A glyph that finds no free code is dropped, but its columns are still consumed.
  function automatic void close_glyph();
    logic [11:0] offs;
    logic [12:0] wid;
    offs        = glyph_start[11:0];
    wid         = 13'(scan_col + 1 - glyph_start);
    glyph_start = scan_col + 1;
    if (glyph_count + SKIPPED_CODES >= CODE_TABLE_SIZE) begin
      table_full = 1'b1;
      return;
    end
    glyph_count++;
    step_out.push_back(status_record(KIND_GLYPH, 8'(SKIPPED_CODES + glyph_count - 1),
                                     offs, wid));
  endfunction

  function automatic void predict_pixel(logic [7:0] a);
    int unsigned w, h;
    bit          col_end;
    step_out.delete();
    w       = clamp_dim(reg_width, MAX_COLUMNS);
    h       = clamp_dim(reg_height, MAX_ROWS);
    col_end = scan_row >= h - 1;
    if (a == 8'd0 && !col_done) begin
      if (glyph_count == 0 && !table_full) begin
        // Every mark of the first marked column widens the line band.
        if (marker_top < 0) marker_top = int'(scan_row);
        marker_bottom = int'(scan_row);
      end else begin
        close_glyph();
        col_done = 1'b1;
      end
    end
    if (col_end) begin
      if (glyph_count == 0 && !table_full && marker_top >= 0) close_glyph();
      if (scan_col >= w - 1) begin
        step_out.push_back(status_record(KIND_SUMMARY, '0, '0, '0));
        restart_scan();
      end else begin
        scan_col = (scan_col + 1) & 32'hFFF;
        scan_row = 0;
        col_done = 1'b0;
      end
    end else begin
      scan_row = (scan_row + 1) & 32'hFF;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_result = 1'b1;
    foreach (step_out[i]) pending_records.push_back(step_out[i]);
  endfunction

  function automatic string show_record(res_t r);
    return $sformatf({"kind=%0d code=%0d offs=%0d width=%0d top=%0d bot=%0d",
                      " total=%0d ovf=%0d last=%0d"},
                     r.kind, r.glyph_code, r.glyph_offset, r.glyph_width, $signed(r.top_row),
                     $signed(r.bottom_row), r.char_total, r.table_overflow, r.last_result);
  endfunction

  // Results are checked before the pixel of the same edge is predicted; a pixel
  // cannot produce a result in the cycle it is accepted.
  always @(posedge clk_i) begin : scoreboard
    res_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.kind           = kind_e'(kind_o);
        got.glyph_code     = glyph_code_o;
        got.glyph_offset   = glyph_offset_o;
        got.glyph_width    = glyph_width_o;
        got.top_row        = top_row_o;
        got.bottom_row     = bottom_row_o;
        got.char_total     = char_total_o;
        got.table_overflow = table_overflow_o;
        got.last_result    = last_result_o;
        if (pending_records.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: %s", show_record(got));
        end else begin
          want = pending_records.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result mismatch: expected %s", show_record(want));
              $display("                 actual   %s", show_record(got));
            end
          end
        end
      end
      if (push && !full) predict_pixel(alpha_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  reg_width  = cfg_data_i;
          REG_IMAGE_HEIGHT: reg_height = cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver changes its stall pattern, picking one of four at random when its run ends.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 2'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM:       pop <= 1'b1;
      RX_COIN:         pop <= ($urandom_range(0, 1) == 1);
      RX_EVERY_FOURTH: pop <= (rx_phase == 2'd0);
      default:         pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic logic [7:0] ink();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_pixel(logic [7:0] a);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push    <= 1'b1;
    alpha_i <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Stops sending and waits until every outstanding result has been popped,
  // then gives pixels that produce no result time to leave the pipeline.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_records.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [12:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(logic [12:0] width_val, logic [12:0] height_val);
    write_reg(REG_IMAGE_WIDTH, width_val);
    write_reg(REG_IMAGE_HEIGHT, height_val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends up to count pixels of a w by h strip. A clean strip has a marker band
  // in one of its first columns and mostly one delimiter per later column.
  task automatic send_strip(int unsigned w, int unsigned h, int unsigned count, bit noisy);
    int unsigned mc, top_r, bot_r, sent, delim;
    logic [7:0]  a;
    mc    = $urandom_range(0, (w > 3) ? 2 : w - 1);
    top_r = $urandom_range(0, h - 1);
    bot_r = $urandom_range(top_r, h - 1);
    sent  = 0;
    for (int unsigned c = 0; c < w && sent < count; c++) begin
      delim = (c > mc && $urandom_range(0, 4) != 0) ? $urandom_range(0, h - 1) : h;
      for (int unsigned r = 0; r < h && sent < count; r++) begin
        if (noisy) a = ($urandom_range(0, 3) == 0) ? 8'd0 : ink();
        else if (c == mc) a = (r >= top_r && r <= bot_r) ? 8'd0 : ink();
        else if (r == delim) a = 8'd0;
        else if (r > delim && $urandom_range(0, 3) == 0) a = 8'd0;
        else a = ink();
        send_pixel(a);
        sent++;
      end
    end
  endtask

  // Default geometry is 4096 by 16; the width is cut mid-image so the strip ends.
  task automatic test_reset_geometry();
    for (int unsigned i = 0; i < 40; i++) begin
      if (i == 5 || i == 6 || i == 16 + 3 || i == 16 + 9) send_pixel(8'd0);
      else send_pixel(ink());
    end
    drain();
    configure(13'd3, 13'd16);
    repeat (8) send_pixel(ink());
    drain();
  endtask

  task automatic test_directed_strip();
    logic [7:0] strip[20] = '{8'd255, 8'd1, 8'd128, 8'd254,
                              8'd7, 8'd0, 8'd9, 8'd0,
                              8'd0, 8'd0, 8'd200, 8'd0,
                              8'd1, 8'd2, 8'd3, 8'd4,
                              8'd5, 8'd6, 8'd7, 8'd0};
    configure(13'd5, 13'd4);
    foreach (strip[i]) send_pixel(strip[i]);
    drain();
    // A zero width and height count as one pixel images.
    configure(13'd0, 13'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    drain();
  endtask

  task automatic test_dimension_extremes();
    configure(13'h1FFF, 13'h1E01);
    repeat (MAX_COLUMNS) send_pixel(($urandom_range(0, 5) == 0) ? 8'd0 : ink());
    drain();
    configure(13'd2, 13'h1FFF);
    send_strip(2, MAX_ROWS, 2 * MAX_ROWS, 1'b0);
    drain();
    configure(13'd3, 13'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    drain();
  endtask

  task automatic test_table_overflow();
    int unsigned mark_row;
    configure(13'd240, 13'd2);
    for (int unsigned c = 0; c < 240; c++) begin
      mark_row = $urandom_range(0, 1);
      for (int unsigned r = 0; r < 2; r++) send_pixel((r == mark_row) ? 8'd0 : ink());
    end
    drain();
    // The next image must start with a clear table.
    configure(13'd2, 13'd1);
    send_pixel(8'd0);
    send_pixel(8'd0);
    drain();
  endtask

  task automatic test_random_strips();
    int unsigned start, w, h, pixels;
    bit          fresh;
    start = pixels_sent;
    fresh = 1'b1;
    w     = 1;
    h     = 1;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (fresh || $urandom_range(0, 1) == 0) begin
        fresh = 1'b0;
        drain();
        case ($urandom_range(0, 9))
          0: begin
            w = $urandom_range(1, 3);
            h = $urandom_range(100, MAX_ROWS);
          end
          1: begin
            w = $urandom_range(100, 300);
            h = 1;
          end
          default: begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 10);
          end
        endcase
        configure(13'(w), 13'(h));
      end
      // Now and then an image is cut short, so the next one starts mid-strip.
      pixels = w * h;
      if ($urandom_range(0, 5) == 0) pixels = $urandom_range(1, w * h);
      send_strip(w, h, pixels, $urandom_range(0, 4) == 0);
    end
    drain();
  endtask

  initial begin
    restart_scan();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_directed_strip();
    test_dimension_extremes();
    test_table_overflow();
    test_random_strips();
    drain();
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
